// ===== rtl/assert_macros.svh =====
// Assertion helpers for the parser RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, muted while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication violated");

// Next-cycle implication, muted while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/rifp_pkg.sv =====
package rifp_pkg;

	localparam int MAX_LEX_NEST = 4;
	localparam int NEST_W       = $clog2(MAX_LEX_NEST + 1);
	localparam logic [NEST_W-1:0] NEST_MAX = NEST_W'(MAX_LEX_NEST);

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] CFG_MODE      = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_RADIX     = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_LIMIT_EN  = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_CHAR_LIM  = 2'd3;

	localparam logic [1:0] MODE_PLAIN   = 2'd0;
	localparam logic [1:0] MODE_LEX_DEC = 2'd1;
	localparam logic [1:0] MODE_LEX_HEX = 2'd2;

	localparam logic [5:0] BASE_MIN = 6'd2;
	localparam logic [5:0] BASE_MAX = 6'd36;
	localparam logic [5:0] BASE_DEC = 6'd10;
	localparam logic [5:0] BASE_HEX = 6'd16;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A_LOW = 8'h61;
	localparam logic [7:0] CH_Z_LOW = 8'h7a;
	localparam logic [7:0] CASE_BIT = 8'h20;

	// Digit code that no base accepts.
	localparam logic [5:0] DIGIT_NONE = 6'd63;

	typedef enum logic [2:0] {
		PH_START,
		PH_LEN,
		PH_SPACE,
		PH_SIGNED,
		PH_DIGITS
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_LIMIT,
		ST_BADDIGIT,
		ST_EOS,
		ST_BADLEN,
		ST_DEEP
	} status_t;

	function automatic logic [5:0] digit_value(input logic [7:0] ch);
		logic [7:0] low;
		logic [7:0] d;
		low = ch | CASE_BIT;
		d = 8'd0;
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			d = ch - CH_ZERO;
			digit_value = d[5:0];
		end else if (low >= CH_A_LOW && low <= CH_Z_LOW) begin
			d = low - CH_A_LOW + 8'd10;
			digit_value = d[5:0];
		end else begin
			digit_value = DIGIT_NONE;
		end
	endfunction

endpackage

// ===== rtl/radix_integer_field_parser.sv =====
// A byte is captured in the input register and its result in the result register, which drives m_tvalid.
// Throughput: one byte per cycle; the input register holds one byte and the result register
// one result, and a byte stalls only while a pending result is not taken.
// Per-byte work is one 32x6 multiply-add plus the field state update.
// Reset: arst_n clears config to mode 0, radix 10, no limit, and returns to field start.
`include "assert_macros.svh"

module radix_integer_field_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rifp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [rifp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [7:0] text_byte
	input  logic [0:0]                        s_tuser,   // [0] command (1 = end of stream)
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [31:0]                       m_tdata,   // [31:0] value
	output logic [3:0]                        m_tuser    // [2:0] status, [3] byte_returned
);
	import rifp_pkg::*;

	// configuration
	logic [1:0]  mode_q;
	logic [5:0]  radix_q;
	logic        limit_en_q;
	logic [15:0] char_limit_q;

	// input register
	logic        valid_s1;
	logic        eos_s1;
	logic [7:0]  byte_s1;

	// field state
	phase_t              phase_q;
	logic                neg_q;
	logic [31:0]         val_q;
	logic [31:0]         chars_q;
	logic [NEST_W-1:0]   nest_q;
	logic [5:0]          base_q;

	// result register
	logic        m_valid_q;
	status_t     status_q;
	logic [31:0] value_q;
	logic        ret_q;

	logic advance;

	// effective state after field start is resolved
	phase_t              e_phase;
	logic                e_neg;
	logic [31:0]         e_val;
	logic [31:0]         e_chars;
	logic [NEST_W-1:0]   e_nest;
	logic [5:0]          e_base;

	phase_t              n_phase;
	logic                n_neg;
	logic [31:0]         n_val;
	logic [31:0]         n_chars;
	logic [NEST_W-1:0]   n_nest;
	logic [5:0]          n_base;

	logic        res_valid;
	status_t     res_status;
	logic [31:0] res_value;
	logic        res_ret;

	logic                lex;
	logic                lim;
	logic [5:0]          lex_base;
	logic [5:0]          plain_base;
	logic [5:0]          dv;
	logic                dig_ok;
	logic [31:0]         dig_term;
	logic [31:0]         mul_val;
	logic [31:0]         take_chars;
	logic                take_done;
	logic [NEST_W-1:0]   nest_dn;
	logic [5:0]          nest_base;
	logic [NEST_W-1:0]   nest_dn2;
	logic [5:0]          nest_base2;
	logic                r_ok;
	logic [31:0]         r_chars;
	logic                r_done;
	logic                redo;
	logic                is_sign;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = value_q;
	assign m_tuser  = {ret_q, status_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_PLAIN;
			radix_q      <= BASE_DEC;
			limit_en_q   <= 1'b0;
			char_limit_q <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_MODE:     mode_q       <= cfg_wdata[1:0];
				CFG_RADIX:    radix_q      <= cfg_wdata[5:0];
				CFG_LIMIT_EN: limit_en_q   <= cfg_wdata[0];
				CFG_CHAR_LIM: char_limit_q <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			eos_s1  <= s_tuser[0];
			byte_s1 <= s_tdata;
		end
	end

	always_comb begin
		lex        = (mode_q == MODE_LEX_DEC) || (mode_q == MODE_LEX_HEX);
		lim        = lex || limit_en_q;
		lex_base   = (mode_q == MODE_LEX_HEX) ? BASE_HEX : BASE_DEC;
		plain_base = radix_q;
		if (radix_q < BASE_MIN) begin
			plain_base = BASE_MIN;
		end else if (radix_q > BASE_MAX) begin
			plain_base = BASE_MAX;
		end

		e_phase = phase_q;
		e_neg   = neg_q;
		e_val   = val_q;
		e_chars = chars_q;
		e_nest  = nest_q;
		e_base  = base_q;
		if (!(phase_q == PH_LEN || phase_q == PH_SPACE || phase_q == PH_SIGNED ||
		      phase_q == PH_DIGITS)) begin
			e_neg  = 1'b0;
			e_val  = 32'd0;
			e_nest = '0;
			if (lex) begin
				e_phase = PH_LEN;
				e_chars = 32'd0;
				e_base  = BASE_DEC;
			end else begin
				e_phase = PH_SPACE;
				e_chars = {16'd0, char_limit_q};
				e_base  = plain_base;
			end
		end

		is_sign    = (byte_s1 == CH_MINUS) || (byte_s1 == CH_PLUS);
		dv         = digit_value(byte_s1);
		dig_ok     = dv < e_base;
		dig_term   = e_neg ? (32'd0 - {26'd0, dv}) : {26'd0, dv};
		// value is kept with its sign applied, so a completed field needs no negate
		mul_val    = e_val * {26'd0, e_base} + dig_term;
		take_chars = lim ? e_chars - 32'd1 : e_chars;
		take_done  = lim && (e_chars == 32'd1);
		nest_dn    = e_nest - NEST_W'(1);
		nest_base  = (nest_dn != '0) ? BASE_DEC : lex_base;
		nest_dn2   = nest_dn - NEST_W'(1);
		nest_base2 = (nest_dn2 != '0) ? BASE_DEC : lex_base;
		r_ok       = dv < nest_base;
		r_chars    = lim ? e_val - 32'd1 : e_val;
		r_done     = lim && (e_val == 32'd1);

		n_phase    = e_phase;
		n_neg      = e_neg;
		n_val      = e_val;
		n_chars    = e_chars;
		n_nest     = e_nest;
		n_base     = e_base;
		res_valid  = 1'b0;
		res_status = ST_OK;
		res_value  = 32'd0;
		res_ret    = 1'b0;
		redo       = 1'b0;

		unique case (e_phase)
			PH_LEN: begin
				if (eos_s1) begin
					res_valid  = 1'b1;
					res_status = ST_EOS;
				end else if (byte_s1 >= CH_ZERO && byte_s1 <= CH_EIGHT) begin
					n_phase = PH_SPACE;
					n_neg   = 1'b0;
					n_val   = 32'd0;
					n_chars = {24'd0, byte_s1 - CH_ZERO};
					n_base  = (e_nest != '0) ? BASE_DEC : lex_base;
					if (byte_s1 == CH_ZERO) begin
						res_valid  = 1'b1;
						res_status = ST_LIMIT;
					end
				end else if (byte_s1 == CH_NINE) begin
					if (e_nest >= NEST_MAX) begin
						res_valid  = 1'b1;
						res_status = ST_DEEP;
					end else begin
						n_nest = e_nest + NEST_W'(1);
					end
				end else begin
					res_valid  = 1'b1;
					res_status = ST_BADLEN;
				end
			end
			PH_SPACE, PH_SIGNED, PH_DIGITS: begin
				if (lim && e_chars == 32'd0) begin
					if (e_phase == PH_DIGITS && e_nest != '0) begin
						if (e_val == 32'd0) begin
							res_valid  = 1'b1;
							res_status = ST_LIMIT;
							res_ret    = !eos_s1;
						end else begin
							redo = 1'b1;
						end
					end else if (e_phase == PH_DIGITS) begin
						res_valid  = 1'b1;
						res_status = ST_OK;
						res_value  = e_val;
						res_ret    = !eos_s1;
					end else begin
						res_valid  = 1'b1;
						res_status = ST_LIMIT;
						res_ret    = !eos_s1;
					end
				end else if (eos_s1) begin
					res_valid = 1'b1;
					if (e_phase == PH_DIGITS && e_nest != '0) begin
						// the field it opens would see end of stream too
						res_status = (e_val == 32'd0) ? ST_LIMIT : ST_EOS;
					end else if (e_phase == PH_DIGITS) begin
						res_status = ST_OK;
						res_value  = e_val;
					end else begin
						res_status = ST_EOS;
					end
				end else if (e_phase == PH_SPACE && byte_s1 == CH_SPACE) begin
					n_chars = take_chars;
					if (take_done) begin
						res_valid  = 1'b1;
						res_status = ST_LIMIT;
					end
				end else if (e_phase == PH_SPACE && is_sign) begin
					n_neg   = (byte_s1 == CH_MINUS);
					n_phase = PH_SIGNED;
					n_chars = take_chars;
					if (take_done) begin
						res_valid  = 1'b1;
						res_status = ST_LIMIT;
					end
				end else if (dig_ok) begin
					n_val   = mul_val;
					n_phase = PH_DIGITS;
					n_chars = take_chars;
					if (take_done) begin
						if (e_nest != '0) begin
							// completed length opens the next field
							n_nest  = nest_dn;
							n_phase = PH_SPACE;
							n_neg   = 1'b0;
							n_val   = 32'd0;
							n_chars = mul_val;
							n_base  = nest_base;
							if (mul_val == 32'd0) begin
								res_valid  = 1'b1;
								res_status = ST_LIMIT;
							end
						end else begin
							res_valid  = 1'b1;
							res_status = ST_OK;
							res_value  = mul_val;
						end
					end
				end else if (e_phase == PH_DIGITS) begin
					if (e_nest != '0) begin
						if (e_val == 32'd0) begin
							res_valid  = 1'b1;
							res_status = ST_LIMIT;
							res_ret    = 1'b1;
						end else begin
							redo = 1'b1;
						end
					end else begin
						res_valid  = 1'b1;
						res_status = ST_OK;
						res_value  = e_val;
						res_ret    = 1'b1;
					end
				end else begin
					res_valid  = 1'b1;
					res_status = ST_BADDIGIT;
					res_ret    = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// A nested length ended on an unconsumed byte: open the next field with
		// that length and present the same byte to it.
		if (redo) begin
			n_nest  = nest_dn;
			n_base  = nest_base;
			n_neg   = 1'b0;
			n_val   = 32'd0;
			n_chars = e_val;
			n_phase = PH_SPACE;
			if (eos_s1) begin
				res_valid  = 1'b1;
				res_status = ST_EOS;
			end else if (byte_s1 == CH_SPACE) begin
				n_chars = r_chars;
				if (r_done) begin
					res_valid  = 1'b1;
					res_status = ST_LIMIT;
				end
			end else if (is_sign) begin
				n_neg   = (byte_s1 == CH_MINUS);
				n_phase = PH_SIGNED;
				n_chars = r_chars;
				if (r_done) begin
					res_valid  = 1'b1;
					res_status = ST_LIMIT;
				end
			end else if (r_ok) begin
				n_val   = {26'd0, dv};
				n_phase = PH_DIGITS;
				n_chars = r_chars;
				if (r_done) begin
					if (nest_dn != '0) begin
						n_nest  = nest_dn2;
						n_phase = PH_SPACE;
						n_val   = 32'd0;
						n_chars = {26'd0, dv};
						n_base  = nest_base2;
						if (dv == 6'd0) begin
							res_valid  = 1'b1;
							res_status = ST_LIMIT;
						end
					end else begin
						res_valid  = 1'b1;
						res_status = ST_OK;
						res_value  = {26'd0, dv};
					end
				end
			end else begin
				res_valid  = 1'b1;
				res_status = ST_BADDIGIT;
				res_ret    = 1'b1;
			end
		end

		// every result ends the field
		if (res_valid) begin
			n_phase = PH_START;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			val_q   <= 32'd0;
			chars_q <= 32'd0;
			nest_q  <= '0;
			base_q  <= BASE_DEC;
		end else if (advance) begin
			phase_q <= n_phase;
			neg_q   <= n_neg;
			val_q   <= n_val;
			chars_q <= n_chars;
			nest_q  <= n_nest;
			base_q  <= n_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			status_q <= res_status;
			value_q  <= res_value;
			ret_q    <= res_ret;
		end
	end

	`ASSERT_IMPLIES(a_value_only_ok, clk, arst_n, m_valid_q && status_q != ST_OK, value_q == 32'd0)

	`ASSERT_IMPLIES(a_return_kinds, clk, arst_n, m_valid_q && ret_q, status_q == ST_OK || status_q == ST_LIMIT || status_q == ST_BADDIGIT)

	`ASSERT_IMPLIES(a_nest_bound, clk, arst_n, 1'b1, nest_q <= NEST_MAX)

	`ASSERT_NEXT(a_field_restart, clk, arst_n, advance && res_valid, phase_q == PH_START)

endmodule

// ===== tb/rifp_field_checker.sv =====
`timescale 1ns / 1ps

module rifp_field_checker
	import rifp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] text_byte
	input  logic [0:0]            s_tuser,   // [0] command (1 = end of stream)
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [31:0]           m_tdata,   // [31:0] value
	input  logic [3:0]            m_tuser,   // [2:0] status, [3] byte_returned
	output int                    errors,
	output int                    pending
);

	localparam int unsigned NOT_A_DIGIT = 64;

	typedef struct packed {
		status_t     status;
		logic [31:0] value;
		logic        returned;
	} field_result_t;

	// register copies
	logic [1:0]  mode_q;
	logic [5:0]  radix_q;
	logic        limit_on_q;
	logic [15:0] char_limit_q;

	// field state
	phase_t      phase;
	logic        negative;
	logic [31:0] acc;
	logic        have_digit;
	logic [31:0] chars_left;
	int unsigned nest_level;
	logic [5:0]  base;

	field_result_t expected_q[$];

	function automatic bit lex_active();
		return mode_q == MODE_LEX_DEC || mode_q == MODE_LEX_HEX;
	endfunction

	function automatic bit length_capped();
		return lex_active() || limit_on_q;
	endfunction

	function automatic logic [5:0] lex_base();
		return (mode_q == MODE_LEX_HEX) ? BASE_HEX : BASE_DEC;
	endfunction

	function automatic void clear_field();
		phase = PH_START;
		negative = 1'b0;
		acc = '0;
		have_digit = 1'b0;
		chars_left = '0;
		nest_level = 0;
		base = BASE_DEC;
	endfunction

	function automatic void open_field(input logic [31:0] limit, input logic [5:0] b);
		phase = PH_SPACE;
		negative = 1'b0;
		acc = '0;
		have_digit = 1'b0;
		chars_left = limit;
		base = b;
	endfunction

	function automatic bit close_field(input status_t st, input logic [31:0] v, input bit ret,
			output field_result_t res);
		res.status = st;
		res.value = v;
		res.returned = ret;
		clear_field();
		return 1'b1;
	endfunction

	// A finished number is either the field value or the length of a nested field.
	function automatic bit finish_number(input bit consumed, input bit eos, output bit again,
			output field_result_t res);
		logic [31:0] v;
		v = negative ? 32'd0 - acc : acc;
		again = 1'b0;
		res = '0;
		if (nest_level != 0) begin
			nest_level--;
			open_field(v, (nest_level != 0) ? BASE_DEC : lex_base());
			if (v == 0)
				return close_field(ST_LIMIT, '0, !consumed && !eos, res);
			again = !consumed;
			return 1'b0;
		end
		return close_field(ST_OK, v, !consumed && !eos, res);
	endfunction

	function automatic bit consume_byte(output field_result_t res);
		bit again;
		res = '0;
		if (length_capped() && chars_left != 0)
			chars_left--;
		if (length_capped() && chars_left == 0) begin
			if (phase == PH_DIGITS)
				return finish_number(1'b1, 1'b0, again, res);
			return close_field(ST_LIMIT, '0, 1'b0, res);
		end
		return 1'b0;
	endfunction

	function automatic bit predict_byte(input bit eos, input logic [7:0] ch,
			output field_result_t res);
		bit again;
		bit got;
		logic [7:0] folded;
		logic [5:0] b;
		int unsigned dv;
		res = '0;
		forever begin
			case (phase)
			PH_START: begin
				if (lex_active()) begin
					phase = PH_LEN;
					nest_level = 0;
				end else begin
					if (radix_q < BASE_MIN)
						b = BASE_MIN;
					else if (radix_q > BASE_MAX)
						b = BASE_MAX;
					else
						b = radix_q;
					open_field({16'd0, char_limit_q}, b);
				end
			end
			PH_LEN: begin
				if (eos)
					return close_field(ST_EOS, '0, 1'b0, res);
				if (ch >= CH_ZERO && ch <= CH_EIGHT) begin
					open_field(32'(ch - CH_ZERO), (nest_level != 0) ? BASE_DEC : lex_base());
					if (ch == CH_ZERO)
						return close_field(ST_LIMIT, '0, 1'b0, res);
					return 1'b0;
				end
				if (ch == CH_NINE) begin
					if (nest_level >= MAX_LEX_NEST)
						return close_field(ST_DEEP, '0, 1'b0, res);
					nest_level++;
					return 1'b0;
				end
				return close_field(ST_BADLEN, '0, 1'b0, res);
			end
			default: begin
				// a spent limit ends the field before the byte is looked at
				if (length_capped() && chars_left == 0) begin
					if (phase != PH_DIGITS)
						return close_field(ST_LIMIT, '0, !eos, res);
					got = finish_number(1'b0, eos, again, res);
					if (!again)
						return got;
				end else if (eos) begin
					if (phase != PH_DIGITS)
						return close_field(ST_EOS, '0, 1'b0, res);
					got = finish_number(1'b0, 1'b1, again, res);
					if (!again)
						return got;
				end else if (phase == PH_SPACE && ch == CH_SPACE) begin
					return consume_byte(res);
				end else if (phase == PH_SPACE && (ch == CH_MINUS || ch == CH_PLUS)) begin
					negative = (ch == CH_MINUS);
					phase = PH_SIGNED;
					return consume_byte(res);
				end else begin
					folded = ch | CASE_BIT;
					if (ch >= CH_ZERO && ch <= CH_NINE)
						dv = ch - CH_ZERO;
					else if (folded >= CH_A_LOW && folded <= CH_Z_LOW)
						dv = folded - CH_A_LOW + 10;
					else
						dv = NOT_A_DIGIT;
					if (dv < base) begin
						acc = acc * base + dv;
						have_digit = 1'b1;
						phase = PH_DIGITS;
						return consume_byte(res);
					end
					if (phase != PH_DIGITS || !have_digit)
						return close_field(ST_BADDIGIT, '0, 1'b1, res);
					// push the byte back and hand it to the next field
					got = finish_number(1'b0, 1'b0, again, res);
					if (!again)
						return got;
				end
			end
			endcase
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		field_result_t want;
		field_result_t fresh;
		if (!arst_n) begin
			mode_q = MODE_PLAIN;
			radix_q = BASE_DEC;
			limit_on_q = 1'b0;
			char_limit_q = '0;
			clear_field();
			expected_q.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
				CFG_MODE:     mode_q = cfg_wdata[1:0];
				CFG_RADIX:    radix_q = cfg_wdata[5:0];
				CFG_LIMIT_EN: limit_on_q = cfg_wdata[0];
				CFG_CHAR_LIM: char_limit_q = cfg_wdata[15:0];
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual status %0d value %h returned %b",
						$time, m_tuser[2:0], m_tdata, m_tuser[3]);
					errors++;
				end else begin
					want = expected_q.pop_front();
					if (m_tuser[2:0] !== want.status) begin
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, want.status, m_tuser[2:0]);
						errors++;
					end
					if (m_tdata !== want.value) begin
						$display("%0t: value mismatch: expected %h, actual %h",
							$time, want.value, m_tdata);
						errors++;
					end
					if (m_tuser[3] !== want.returned) begin
						$display("%0t: byte_returned mismatch: expected %b, actual %b",
							$time, want.returned, m_tuser[3]);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (predict_byte(s_tuser[0], s_tdata, fresh))
					expected_q.push_back(fresh);
			end
			pending <= expected_q.size();
		end
	end

endmodule

// ===== tb/tb_radix_integer_field_parser.sv =====
`timescale 1ns / 1ps

module tb_radix_integer_field_parser;
	import rifp_pkg::*;

	localparam int TARGET_ITEMS  = 400;
	localparam int SETTLE_CYCLES = 6;
	localparam int STALL_LIMIT   = 2000;

	localparam logic [0:0] CMD_TEXT = 1'b0;
	localparam logic [0:0] CMD_END  = 1'b1;

	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;   // [7:0] text_byte
	logic [0:0]            s_tuser;   // [0] command (1 = end of stream)
	logic                  m_tvalid;
	logic                  m_tready;
	logic [31:0]           m_tdata;   // [31:0] value
	logic [3:0]            m_tuser;   // [2:0] status, [3] byte_returned

	int errors;
	int pending;
	int items_sent = 0;
	int idle_cycles = 0;
	bit src_fast = 1'b0;
	bit sink_fast = 1'b0;
	logic [1:0] cur_mode = MODE_PLAIN;
	logic [5:0] cur_radix = BASE_DEC;

	radix_integer_field_parser dut (.*);

	rifp_field_checker field_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stall limit: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("[radix_integer_field_parser] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side: random stall before each transfer, with stretches of none
	initial begin
		int gap;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = sink_fast ? 0 : $urandom_range(0, 9);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if ($urandom_range(0, 63) == 0)
				sink_fast = !sink_fast;
		end
	end

	task automatic push_item(input logic [0:0] cmd, input logic [7:0] ch);
		int gap;
		gap = src_fast ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ch;
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if ($urandom_range(0, 63) == 0)
			src_fast = !src_fast;
	endtask

	task automatic send_text(input string t);
		foreach (t[i])
			push_item(CMD_TEXT, t[i]);
	endtask

	task automatic send_eos();
		push_item(CMD_END, 8'($urandom_range(0, 255)));
	endtask

	// wait for every expected result, then let the pipeline empty
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data,
			input bit last);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		if (last)
			cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [1:0] mode, input logic [5:0] rdx, input logic lim_on,
			input logic [15:0] lim);
		logic [15:0] junk;
		junk = 16'($urandom);
		drain();
		// fill unused upper bits with noise
		write_reg(CFG_MODE, {junk[15:2], mode}, 1'b0);
		write_reg(CFG_RADIX, {junk[15:6], rdx}, 1'b0);
		write_reg(CFG_LIMIT_EN, {junk[15:1], lim_on}, 1'b0);
		write_reg(CFG_CHAR_LIM, lim, 1'b1);
		cur_mode = mode;
		cur_radix = rdx;
	endtask

	function automatic int unsigned field_base();
		if (cur_mode == MODE_LEX_HEX)
			return BASE_HEX;
		if (cur_mode == MODE_LEX_DEC)
			return BASE_DEC;
		if (cur_radix < BASE_MIN)
			return BASE_MIN;
		if (cur_radix > BASE_MAX)
			return BASE_MAX;
		return cur_radix;
	endfunction

	function automatic logic [7:0] digit_char(input int unsigned b);
		int unsigned v;
		logic [7:0] c;
		v = $urandom_range(0, b - 1);
		if (v < 10) begin
			c = CH_ZERO + 8'(v);
		end else begin
			c = CH_A_LOW + 8'(v - 10);
			if ($urandom_range(0, 1) != 0)
				c = c & ~CASE_BIT;
		end
		return c;
	endfunction

	task automatic plain_field();
		int unsigned b;
		b = field_base();
		repeat ($urandom_range(0, 2))
			push_item(CMD_TEXT, CH_SPACE);
		case ($urandom_range(0, 3))
		0: push_item(CMD_TEXT, CH_MINUS);
		1: push_item(CMD_TEXT, CH_PLUS);
		default: ;
		endcase
		repeat (($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8))
			push_item(CMD_TEXT, digit_char(b));
		case ($urandom_range(0, 3))
		0: push_item(CMD_TEXT, CH_SPACE);
		1: push_item(CMD_TEXT, 8'($urandom_range(0, 255)));
		default: ;
		endcase
	endtask

	task automatic lex_field();
		int unsigned b;
		int unsigned len;
		int unsigned r;
		b = field_base();
		case ($urandom_range(0, 7))
		0: begin
			// one nested decimal length in front of the value
			len = $urandom_range(1, 16);
			push_item(CMD_TEXT, CH_NINE);
			if (len < 10) begin
				push_item(CMD_TEXT, CH_ZERO + 8'd1);
				push_item(CMD_TEXT, CH_ZERO + 8'(len));
			end else begin
				push_item(CMD_TEXT, CH_ZERO + 8'd2);
				push_item(CMD_TEXT, CH_ZERO + 8'd1);
				push_item(CMD_TEXT, CH_ZERO + 8'(len - 10));
			end
		end
		1: begin
			// nesting chain, sometimes too deep
			repeat ($urandom_range(2, 6))
				push_item(CMD_TEXT, CH_NINE);
			len = $urandom_range(1, 8);
			push_item(CMD_TEXT, CH_ZERO + 8'(len));
		end
		default: begin
			len = $urandom_range(0, 8);
			push_item(CMD_TEXT, CH_ZERO + 8'(len));
		end
		endcase
		for (int unsigned i = 0; i < len; i++) begin
			r = $urandom_range(0, 9);
			if (i == 0 && r == 0)
				push_item(CMD_TEXT, ($urandom_range(0, 1) != 0) ? CH_MINUS : CH_PLUS);
			else if (r == 1)
				push_item(CMD_TEXT, 8'($urandom_range(0, 255)));
			else
				push_item(CMD_TEXT, digit_char(b));
		end
	endtask

	initial begin
		int unsigned pick;
		logic [5:0] rdx;
		logic [15:0] lim;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_TEXT;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: signed decimal cut by a letter, then stream end with no field
		send_text(" -42g");
		send_eos();

		// unused mode and radix above range; extreme bytes end the field and fail the next
		configure(MODE_UNUSED, 6'd63, 1'b1, 16'hFFFF);
		send_text("+zZ");
		push_item(CMD_TEXT, 8'hFF);
		push_item(CMD_TEXT, 8'h00);
		send_eos();

		// radix below range with a zero limit
		configure(MODE_PLAIN, 6'd0, 1'b1, 16'd0);
		send_text("1");
		send_eos();

		// radix change in the middle of a field
		configure(MODE_PLAIN, BASE_DEC, 1'b0, 16'd0);
		send_text("12");
		drain();
		write_reg(CFG_RADIX, 16'(BASE_HEX), 1'b1);
		cur_radix = BASE_HEX;
		send_text("f");
		send_eos();

		// accumulator and negation wrap
		configure(MODE_PLAIN, BASE_MAX, 1'b0, 16'd0);
		send_text("-zzzzzzzz");
		send_eos();

		// zero length, negative nested length, too deep, bad prefix,
		// nested zero, nested length cut by stream end
		configure(MODE_LEX_DEC, BASE_DEC, 1'b0, 16'd0);
		send_text("093-1277x99999a910921");
		send_eos();

		// hex value behind a nested length, signed short field, lone length at stream end
		configure(MODE_LEX_HEX, BASE_DEC, 1'b0, 16'd0);
		send_text("92108badF00d 3-ff5");
		send_eos();

		while (items_sent < TARGET_ITEMS) begin
			case ($urandom_range(0, 5))
			0: rdx = 6'($urandom_range(0, 63));
			1: rdx = BASE_MIN;
			2: rdx = BASE_MAX;
			3: rdx = BASE_HEX;
			default: rdx = 6'($urandom_range(2, 36));
			endcase
			case ($urandom_range(0, 5))
			0: lim = 16'd0;
			1: lim = 16'hFFFF;
			2: lim = 16'($urandom_range(0, 65535));
			default: lim = 16'($urandom_range(1, 12));
			endcase
			configure(2'($urandom_range(0, 3)), rdx, 1'($urandom_range(0, 1)), lim);
			repeat ($urandom_range(2, 6)) begin
				pick = $urandom_range(0, 9);
				if (pick == 0)
					repeat ($urandom_range(1, 3))
						push_item(CMD_TEXT, 8'($urandom_range(0, 255)));
				else if (cur_mode == MODE_LEX_DEC || cur_mode == MODE_LEX_HEX)
					lex_field();
				else
					plain_field();
			end
			send_eos();
		end

		drain();
		if (errors == 0)
			$display("[radix_integer_field_parser] OK");
		else
			$display("[radix_integer_field_parser] ERROR");
		$finish;
	end

endmodule
